/* hw/rtl/x64_unwind_code_walker_defines.svh */
// Assertion macros used by the unwind code walker RTL.
// Included by uwc_exec, the file that carries concurrent checks; no other dependencies.
`ifndef X64_UNWIND_CODE_WALKER_DEFINES_SVH
`define X64_UNWIND_CODE_WALKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clock and disabled in reset.
`define UWC_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication, clocked on clock and disabled in reset.
`define UWC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define UWC_ASSERT_SAME(label, pre, post, msg)
`define UWC_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* hw/rtl/uwc_pkg.sv */
// Types, codes and helpers for the x64 unwind code walker.
// Has no dependencies; every other RTL file but the assertion macro header refers to it by scoped names.
package uwc_pkg;

   localparam int unsigned ADDR_W = 64;
   localparam int unsigned SLOT_W = 16;

   // Opcode of an input beat.
   typedef enum logic [1:0] {
      OPC_BEGIN  = 2'd0,
      OPC_SLOT   = 2'd1,
      OPC_REPLY  = 2'd2,
      OPC_FINISH = 2'd3
   } opcode_type;

   // Kind of a result beat.
   typedef enum logic [1:0] {
      KIND_RESTORE = 2'd0,
      KIND_LOAD_SP = 2'd1,
      KIND_FINAL   = 2'd2
   } kind_type;

   // What an outstanding memory reply will overwrite.
   typedef enum logic [1:0] {
      WAIT_NONE = 2'd0,
      WAIT_FP   = 2'd1,
      WAIT_SP   = 2'd2
   } wait_type;

   // Unwind operation codes in bits 11:8 of the first slot.
   localparam logic [3:0] UOP_PUSH          = 4'd0;
   localparam logic [3:0] UOP_ALLOC_LARGE   = 4'd1;
   localparam logic [3:0] UOP_ALLOC_SMALL   = 4'd2;
   localparam logic [3:0] UOP_SET_FRAME     = 4'd3;
   localparam logic [3:0] UOP_SAVE          = 4'd4;
   localparam logic [3:0] UOP_SAVE_FAR      = 4'd5;
   localparam logic [3:0] UOP_XMM_SAVE      = 4'd8;
   localparam logic [3:0] UOP_XMM_SAVE_FAR  = 4'd9;
   localparam logic [3:0] UOP_MACHINE_FRAME = 4'd10;

   // Registers 3, 5-7 and 12-15 can be restored.
   localparam logic [15:0] RESTORABLE_MASK = 16'hF0E8;
   localparam logic [3:0]  REG_FRAME       = 4'd5;

   // Payload of one input beat.
   typedef struct packed {
      opcode_type        opcode;
      logic [ADDR_W-1:0] stack_pointer;
      logic [ADDR_W-1:0] frame_pointer;
      logic [ADDR_W-1:0] code_pc;
      logic [ADDR_W-1:0] function_start;
      logic [7:0]        prologue_size;
      logic [3:0]        frame_offset;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] memory_word;
   } req_beat_type;

   // Input register contents handed to the execute logic.
   typedef struct packed {
      logic         valid;
      req_beat_type beat;
   } stage_type;

   // One result beat, with its valid flag.
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [3:0]        register_number;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] final_stack;
   } rsp_beat_type;

   // True when the register can be restored from the stack.
   function automatic logic restorable(input logic [3:0] reg_num);
      return RESTORABLE_MASK[reg_num];
   endfunction

endpackage

/* hw/rtl/uwc_if.sv */
// Valid/ready channel interfaces for the unwind code walker.
// Depends on uwc_pkg for field widths.
interface uwc_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [uwc_pkg::ADDR_W-1:0]  stack_pointer;
   logic [uwc_pkg::ADDR_W-1:0]  frame_pointer;
   logic [uwc_pkg::ADDR_W-1:0]  code_pc;
   logic [uwc_pkg::ADDR_W-1:0]  function_start;
   logic [7:0]                  prologue_size;
   logic [3:0]                  frame_offset;
   logic [uwc_pkg::SLOT_W-1:0]  slot;
   logic [uwc_pkg::ADDR_W-1:0]  memory_word;

   modport source (
      output valid, opcode, stack_pointer, frame_pointer, code_pc, function_start,
             prologue_size, frame_offset, slot, memory_word,
      input  ready
   );
   modport sink (
      input  valid, opcode, stack_pointer, frame_pointer, code_pc, function_start,
             prologue_size, frame_offset, slot, memory_word,
      output ready
   );
endinterface

interface uwc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic [3:0]                  register_number;
   logic [uwc_pkg::ADDR_W-1:0]  address;
   logic [uwc_pkg::ADDR_W-1:0]  final_stack;

   modport source (
      output valid, kind, register_number, address, final_stack,
      input  ready
   );
   modport sink (
      input  valid, kind, register_number, address, final_stack,
      output ready
   );
endinterface

/* hw/rtl/uwc_in_stage.sv */
// Input register of the unwind code walker: captures one request beat.
// Depends on uwc_pkg.
module uwc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  uwc_pkg::req_beat_type in_beat,
   output logic                  in_ready,
   input  logic                  advance,
   output uwc_pkg::stage_type    stage
);

   logic                  valid_ff, valid_in;
   uwc_pkg::req_beat_type beat_ff;

   // The register takes a beat when empty or when its beat moves on this cycle.
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= in_beat;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.beat  = beat_ff;

endmodule

/* hw/rtl/uwc_exec.sv */
// Execute logic of the unwind code walker: walker state and combinational decode.
// Depends on uwc_pkg and the assertion macros in x64_unwind_code_walker_defines.svh.
`include "x64_unwind_code_walker_defines.svh"

module uwc_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  uwc_pkg::stage_type    stage,
   input  logic                  fire,
   output uwc_pkg::rsp_beat_type result
);

   logic [63:0]       sp_ff, sp_in;
   logic [63:0]       fp_ff, fp_in;
   logic [63:0]       co_ff, co_in;
   logic [7:0]        pl_ff, pl_in;
   logic [3:0]        scale_ff, scale_in;
   logic [1:0]        pend_ff, pend_in;
   logic [3:0]        pop_ff, pop_in;
   logic [3:0]        pinfo_ff, pinfo_in;
   logic              pact_ff, pact_in;
   logic [15:0]       extra_ff, extra_in;
   uwc_pkg::wait_type wait_ff, wait_in;

   logic [15:0] slot;
   logic [7:0]  offs;
   logic [3:0]  uop;
   logic [3:0]  info;
   logic        in_prologue;
   logic        active;
   logic [1:0]  extra_cnt;
   logic [63:0] sp_plus8;
   logic [63:0] sp_plus_small;
   logic [63:0] sp_plus_scaled;
   logic [63:0] sp_plus_wide;
   logic [63:0] sp_mf;
   logic [63:0] sp_mf_addr;
   logic [63:0] fp_minus;
   logic [63:0] ctrl_offset;
   logic        rst_req;
   logic [3:0]  rst_reg;
   logic [63:0] rst_addr;
   uwc_pkg::rsp_beat_type res;

   // Slot fields and the skip test against the prologue.
   assign slot        = stage.beat.slot;
   assign offs        = slot[7:0];
   assign uop         = slot[11:8];
   assign info        = slot[15:12];
   assign in_prologue = co_ff < {56'd0, pl_ff};
   assign active      = !(in_prologue && ({56'd0, offs} > co_ff));

   // Number of extra slots the code owns.
   always_comb begin
      case (uop)
         uwc_pkg::UOP_ALLOC_LARGE:  extra_cnt = (info == 4'd0) ? 2'd1 : 2'd2;
         uwc_pkg::UOP_SAVE:         extra_cnt = 2'd1;
         uwc_pkg::UOP_XMM_SAVE:     extra_cnt = 2'd1;
         uwc_pkg::UOP_SAVE_FAR:     extra_cnt = 2'd2;
         uwc_pkg::UOP_XMM_SAVE_FAR: extra_cnt = 2'd2;
         default:                   extra_cnt = 2'd0;
      endcase
   end

   // Candidate addresses, each a single add or subtract in parallel, and the clamped code offset.
   assign sp_plus8       = sp_ff + 64'd8;
   assign sp_plus_small  = sp_ff + {56'd0, ({1'b0, info} + 5'd1), 3'b000};
   assign sp_plus_scaled = sp_ff + {45'd0, slot, 3'b000};
   assign sp_plus_wide   = sp_ff + {32'd0, slot, extra_ff};
   assign sp_mf          = sp_ff + ((info != 4'd0) ? 64'd8 : 64'd0);
   assign sp_mf_addr     = sp_ff + ((info != 4'd0) ? 64'd32 : 64'd24);
   assign fp_minus       = fp_ff - {56'd0, scale_ff, 4'b0000};
   assign ctrl_offset    = (stage.beat.code_pc >= stage.beat.function_start) ?
                           (stage.beat.code_pc - stage.beat.function_start) : 64'd0;

   // Next state and result for the beat in the input register.
   always_comb begin
      sp_in    = sp_ff;
      fp_in    = fp_ff;
      co_in    = co_ff;
      pl_in    = pl_ff;
      scale_in = scale_ff;
      pend_in  = pend_ff;
      pop_in   = pop_ff;
      pinfo_in = pinfo_ff;
      pact_in  = pact_ff;
      extra_in = extra_ff;
      wait_in  = wait_ff;
      res      = '0;
      rst_req  = 1'b0;
      rst_reg  = info;
      rst_addr = sp_ff;
      if (fire) begin
         case (stage.beat.opcode)
            uwc_pkg::OPC_BEGIN: begin
               sp_in    = stage.beat.stack_pointer;
               fp_in    = stage.beat.frame_pointer;
               co_in    = ctrl_offset;
               pl_in    = stage.beat.prologue_size;
               scale_in = stage.beat.frame_offset;
               pend_in  = 2'd0;
               pop_in   = 4'd0;
               pinfo_in = 4'd0;
               pact_in  = 1'b0;
               extra_in = 16'd0;
               wait_in  = uwc_pkg::WAIT_NONE;
            end
            uwc_pkg::OPC_REPLY: begin
               case (wait_ff)
                  uwc_pkg::WAIT_FP: fp_in = stage.beat.memory_word;
                  uwc_pkg::WAIT_SP: sp_in = stage.beat.memory_word;
                  default: ;
               endcase
               wait_in = uwc_pkg::WAIT_NONE;
            end
            uwc_pkg::OPC_FINISH: begin
               if (wait_ff == uwc_pkg::WAIT_NONE) begin
                  pend_in           = 2'd0;
                  pact_in           = 1'b0;
                  res.valid         = 1'b1;
                  res.kind          = uwc_pkg::KIND_FINAL;
                  res.address       = sp_ff;
                  res.final_stack   = sp_plus8;
                  sp_in             = sp_plus8;
               end
            end
            uwc_pkg::OPC_SLOT: begin
               if (wait_ff == uwc_pkg::WAIT_NONE) begin
                  if (pend_ff == 2'd2) begin
                     // Low half of a 32-bit operand.
                     extra_in = slot;
                     pend_in  = 2'd1;
                  end else if (pend_ff != 2'd0) begin
                     // Last slot of a multi-slot code.
                     pend_in = 2'd0;
                     if (pact_ff) begin
                        case (pop_ff)
                           uwc_pkg::UOP_ALLOC_LARGE: begin
                              sp_in = (pinfo_ff == 4'd0) ? sp_plus_scaled : sp_plus_wide;
                           end
                           uwc_pkg::UOP_SAVE: begin
                              rst_req  = 1'b1;
                              rst_reg  = pinfo_ff;
                              rst_addr = sp_plus_scaled;
                           end
                           uwc_pkg::UOP_SAVE_FAR: begin
                              rst_req  = 1'b1;
                              rst_reg  = pinfo_ff;
                              rst_addr = sp_plus_wide;
                           end
                           default: ;
                        endcase
                     end
                  end else if (extra_cnt != 2'd0) begin
                     // First slot of a multi-slot code.
                     pend_in  = extra_cnt;
                     pop_in   = uop;
                     pinfo_in = info;
                     pact_in  = active;
                     extra_in = 16'd0;
                  end else if (active) begin
                     case (uop)
                        uwc_pkg::UOP_PUSH: begin
                           rst_req  = 1'b1;
                           rst_addr = sp_ff;
                           sp_in    = sp_plus8;
                        end
                        uwc_pkg::UOP_ALLOC_SMALL: sp_in = sp_plus_small;
                        uwc_pkg::UOP_SET_FRAME:   sp_in = fp_minus;
                        uwc_pkg::UOP_MACHINE_FRAME: begin
                           sp_in       = sp_mf;
                           wait_in     = uwc_pkg::WAIT_SP;
                           res.valid   = 1'b1;
                           res.kind    = uwc_pkg::KIND_LOAD_SP;
                           res.address = sp_mf_addr;
                        end
                        default: ;
                     endcase
                  end
               end
            end
            default: ;
         endcase
         // Register restore; the frame register then waits for its value.
         if (rst_req && uwc_pkg::restorable(rst_reg)) begin
            res.valid           = 1'b1;
            res.kind            = uwc_pkg::KIND_RESTORE;
            res.register_number = rst_reg;
            res.address         = rst_addr;
            if (rst_reg == uwc_pkg::REG_FRAME) begin
               wait_in = uwc_pkg::WAIT_FP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff    <= 64'd0;
         fp_ff    <= 64'd0;
         co_ff    <= 64'd0;
         pl_ff    <= 8'd0;
         scale_ff <= 4'd0;
         pend_ff  <= 2'd0;
         pop_ff   <= 4'd0;
         pinfo_ff <= 4'd0;
         pact_ff  <= 1'b0;
         extra_ff <= 16'd0;
         wait_ff  <= uwc_pkg::WAIT_NONE;
      end else begin
         sp_ff    <= sp_in;
         fp_ff    <= fp_in;
         co_ff    <= co_in;
         pl_ff    <= pl_in;
         scale_ff <= scale_in;
         pend_ff  <= pend_in;
         pop_ff   <= pop_in;
         pinfo_ff <= pinfo_in;
         pact_ff  <= pact_in;
         extra_ff <= extra_in;
         wait_ff  <= wait_in;
      end
   end

   assign result = res;

   // A machine-frame request leaves the walker waiting for the new stack pointer.
   `UWC_ASSERT_NEXT(a_load_sp_waits, fire && res.valid && (res.kind == uwc_pkg::KIND_LOAD_SP), wait_ff == uwc_pkg::WAIT_SP, "load request did not arm the wait")
   // A code never owes more than two extra slots.
   `UWC_ASSERT_SAME(a_pending_range, 1'b1, pend_ff != 2'd3, "pending slot count out of range")
   // Nothing is produced while a memory reply is outstanding.
   `UWC_ASSERT_SAME(a_quiet_when_waiting, fire && (wait_ff != uwc_pkg::WAIT_NONE), !res.valid, "result produced while waiting")
   // A begin beat clears every pending code and wait.
   `UWC_ASSERT_NEXT(a_begin_clears, fire && (stage.beat.opcode == uwc_pkg::OPC_BEGIN), (wait_ff == uwc_pkg::WAIT_NONE) && (pend_ff == 2'd0), "begin left state behind")

endmodule

/* hw/rtl/uwc_out_stage.sv */
// Result register of the unwind code walker: holds one response beat.
// Depends on uwc_pkg.
module uwc_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  uwc_pkg::rsp_beat_type result,
   input  logic                  out_ready,
   output logic                  out_valid,
   output uwc_pkg::rsp_beat_type out_beat,
   output logic                  free
);

   logic                  valid_ff, valid_in;
   uwc_pkg::rsp_beat_type beat_ff;

   // The register can load when empty or when its beat is taken this cycle.
   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = result.valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (fire && result.valid) begin
         beat_ff <= result;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

/* hw/rtl/x64_unwind_code_walker.sv */
// Top level of the x64 unwind code walker.
// Depends on uwc_pkg, uwc_if, uwc_in_stage, uwc_exec and uwc_out_stage.
//
// The walker takes one request beat per clock while responses are taken, and gives at most
// one response beat for it. A beat passes an input register, then combinational decode and
// state update, and lands in a result register, from which the response is presented.
// Throughput is one beat per cycle, set by the update of the stack pointer, frame pointer
// and pending-code state at each beat; a stalled response stalls the input only when both
// registers hold beats. Memory replies are ordinary request beats.
module x64_unwind_code_walker (
   input logic       clock,
   input logic       reset,
   uwc_req_if.sink   req_bus,
   uwc_rsp_if.source rsp_bus
);

   uwc_pkg::req_beat_type req_beat;
   uwc_pkg::stage_type    stage;
   uwc_pkg::rsp_beat_type result;
   uwc_pkg::rsp_beat_type rsp_beat;
   logic                  out_free;
   logic                  fire;

   // Gather the request fields into one beat.
   assign req_beat.opcode         = uwc_pkg::opcode_type'(req_bus.opcode);
   assign req_beat.stack_pointer  = req_bus.stack_pointer;
   assign req_beat.frame_pointer  = req_bus.frame_pointer;
   assign req_beat.code_pc        = req_bus.code_pc;
   assign req_beat.function_start = req_bus.function_start;
   assign req_beat.prologue_size  = req_bus.prologue_size;
   assign req_beat.frame_offset   = req_bus.frame_offset;
   assign req_beat.slot           = req_bus.slot;
   assign req_beat.memory_word    = req_bus.memory_word;

   // The held beat executes once the result register can take its outcome.
   assign fire = stage.valid && out_free;

   uwc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_beat  (req_beat),
      .in_ready (req_bus.ready),
      .advance  (fire),
      .stage    (stage)
   );

   uwc_exec u_exec (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .fire   (fire),
      .result (result)
   );

   uwc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_beat  (rsp_beat),
      .free      (out_free)
   );

   // Drive the response fields.
   assign rsp_bus.kind            = rsp_beat.kind;
   assign rsp_bus.register_number = rsp_beat.register_number;
   assign rsp_bus.address         = rsp_beat.address;
   assign rsp_bus.final_stack     = rsp_beat.final_stack;

endmodule
